// ----- rtl/fsct_pkg.sv -----
// Shared constants, types and helpers of the flow-shop completion-time evaluator.
package fsct_pkg;

   localparam int MACHINES = 16;
   localparam int JOBS     = 256;

   localparam int OPCODE_W = 2;
   localparam int MACH_W   = 4;
   localparam int JOB_W    = 8;
   localparam int PTIME_W  = 16;
   localparam int END_W    = 5;
   localparam int COMP_W   = 32;
   localparam int FLOW_W   = 48;

   localparam int MIDX_W    = (MACHINES > 1) ? $clog2(MACHINES) : 1;
   localparam int MCNT_W    = $clog2(MACHINES + 1);
   localparam int TAB_DEPTH = MACHINES * JOBS;
   localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_APPEND = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_WALK,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // Row-major position of a machine/job pair in the processing-time table.
   function automatic logic [TAB_AW-1:0] table_addr(input logic [MIDX_W-1:0] m,
                                                    input logic [JOB_W-1:0]  j);
      return TAB_AW'(int'(m) * JOBS + int'(j));
   endfunction

endpackage

// ----- rtl/fsct_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fsct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/flow_shop_completion_time_eval.sv -----
// Top level of the flow-shop completion-time evaluator: sequencer, shared adders and state.
//
// Usage. An item is offered on the req_ ports with start high and is taken at a rising
// edge where busy is low. Opcode load writes req_proc_time into the machine-by-job table,
// append walks the pseudo-job req_job_id over machines req_first_machine up to, but not
// including, req_end_machine, and clear zeroes the completion times, the flow sums, the
// running maximum and the saturation flag. Every item yields exactly one result, shown for
// a single cycle with rsp_valid high; the receiver cannot hold it off.
//
// Timing. Load, clear, the unused opcode and an append that visits no machine give their
// result in the cycle after acceptance. An append that visits machines passes through a
// preparation state that fetches the previous machine's completion and the first table
// entry, a walk that takes each machine in turn through the shared completion adder (the
// table RAM delivers one entry per cycle), then a state to drain the flow-sum
// adder, and one for the result. The next item may be taken the cycle after that.
//
// Reset clears the completion and flow state, the maximum and the flag, and leaves the
// block idle. The processing-time table keeps its contents over reset and clear.
module flow_shop_completion_time_eval (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fsct_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [fsct_pkg::MACH_W-1:0]   req_table_machine,
   input  logic [fsct_pkg::JOB_W-1:0]    req_table_job,
   input  logic [fsct_pkg::PTIME_W-1:0]  req_proc_time,
   input  logic [fsct_pkg::JOB_W-1:0]    req_job_id,
   input  logic [fsct_pkg::MACH_W-1:0]   req_first_machine,
   input  logic [fsct_pkg::END_W-1:0]    req_end_machine,
   output logic                          rsp_valid,
   output logic [fsct_pkg::FLOW_W-1:0]   rsp_total_flow,
   output logic [fsct_pkg::COMP_W-1:0]   rsp_job_completion,
   output logic                          rsp_saturated
);

   localparam int MACHINES = fsct_pkg::MACHINES;
   localparam int MIDX_W   = fsct_pkg::MIDX_W;
   localparam int MCNT_W   = fsct_pkg::MCNT_W;
   localparam int COMP_W   = fsct_pkg::COMP_W;
   localparam int FLOW_W   = fsct_pkg::FLOW_W;

   fsct_pkg::state_type  state_ff, state_in;
   fsct_pkg::opcode_type op;

   // Sequencer context of the item at work.
   logic [fsct_pkg::JOB_W-1:0] job_ff, job_in;
   logic [MIDX_W-1:0]          cur_m_ff, cur_m_in;
   logic [MCNT_W-1:0]          end_ff, end_in;
   logic [COMP_W-1:0]          prev_ff, prev_in;

   // Evaluation state.
   logic [COMP_W-1:0] comp_ff [MACHINES];
   logic [COMP_W-1:0] comp_in [MACHINES];
   logic [FLOW_W-1:0] flow_ff [MACHINES];
   logic [FLOW_W-1:0] flow_in [MACHINES];
   logic [FLOW_W-1:0] max_ff, max_in;
   logic              sat_ff, sat_in;
   logic [COMP_W-1:0] cout_ff, cout_in;

   // Flow stage, one machine behind the completion stage.
   logic              fv_ff, fv_in;
   logic [MIDX_W-1:0] fm_ff, fm_in;
   logic [COMP_W-1:0] c_ff, c_in;

   logic                         accept;
   logic                         load_ok;
   logic                         append_ok;
   logic [MCNT_W-1:0]            end_clip;
   logic                         tab_we;
   logic [fsct_pkg::TAB_AW-1:0]  tab_waddr;
   logic [fsct_pkg::TAB_AW-1:0]  tab_raddr;
   logic [fsct_pkg::PTIME_W-1:0] tab_rdata;
   logic [MIDX_W-1:0]            next_m;
   logic [MIDX_W-1:0]            comp_raddr;
   logic [COMP_W-1:0]            comp_rd;
   logic [COMP_W-1:0]            prev_load;
   logic [COMP_W-1:0]            start_t;
   logic [COMP_W:0]              csum;
   logic [COMP_W-1:0]            c_new;
   logic [FLOW_W:0]              fsum;
   logic [FLOW_W-1:0]            f_new;
   logic                         last_m;

   // ---------------------------------------------------------------- decode
   assign op        = fsct_pkg::opcode_type'(req_opcode);
   assign accept    = start && (state_ff == fsct_pkg::ST_IDLE);
   assign load_ok   = (int'(req_table_machine) < MACHINES) &&
                      (int'(req_table_job) < fsct_pkg::JOBS);
   assign end_clip  = (int'(req_end_machine) > MACHINES) ? MCNT_W'(MACHINES)
                                                          : MCNT_W'(req_end_machine);
   assign append_ok = (int'(req_job_id) < fsct_pkg::JOBS) &&
                      (int'(req_first_machine) < int'(end_clip));

   // ------------------------------------------------------ processing table
   // A load writes straight from the request; the walk reads one entry ahead so
   // that the entry for the current machine is ready as the RAM's registered output.
   assign tab_we    = accept && (op == fsct_pkg::OP_LOAD) && load_ok;
   assign tab_waddr = fsct_pkg::table_addr(MIDX_W'(req_table_machine), req_table_job);
   assign next_m    = cur_m_ff + 1'b1;
   assign tab_raddr = fsct_pkg::table_addr((state_ff == fsct_pkg::ST_PREP) ? cur_m_ff
                                                                            : next_m,
                                           job_ff);

   fsct_ram #(
      .WIDTH (fsct_pkg::PTIME_W),
      .DEPTH (fsct_pkg::TAB_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (req_proc_time),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata)
   );

   // ------------------------------------------------------ completion stage
   // One read port on the completion array: in the preparation cycle it fetches the
   // machine before the first one, during the walk the current machine.
   assign comp_raddr = (state_ff == fsct_pkg::ST_PREP) ? (cur_m_ff - 1'b1) : cur_m_ff;
   assign comp_rd    = comp_ff[comp_raddr];
   // Machine 0 has no predecessor, so it starts from its own completion alone.
   assign prev_load  = (cur_m_ff == '0) ? '0 : comp_rd;
   assign start_t    = (comp_rd > prev_ff) ? comp_rd : prev_ff;
   assign csum       = {1'b0, start_t} + (COMP_W + 1)'(tab_rdata);
   assign c_new      = csum[COMP_W] ? '1 : csum[COMP_W-1:0];
   assign last_m     = (MCNT_W'(cur_m_ff) + 1'b1) == end_ff;

   // ------------------------------------------------------------ flow stage
   assign fsum  = {1'b0, flow_ff[fm_ff]} + (FLOW_W + 1)'(c_ff);
   assign f_new = fsum[FLOW_W] ? '1 : fsum[FLOW_W-1:0];

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsct_pkg::ST_IDLE: begin
            if (accept) begin
               if ((op == fsct_pkg::OP_APPEND) && append_ok) begin
                  state_in = fsct_pkg::ST_PREP;
               end else begin
                  state_in = fsct_pkg::ST_RESP;
               end
            end
         end
         fsct_pkg::ST_PREP: begin
            state_in = fsct_pkg::ST_WALK;
         end
         fsct_pkg::ST_WALK: begin
            if (last_m) begin
               state_in = fsct_pkg::ST_DRAIN;
            end
         end
         fsct_pkg::ST_DRAIN: begin
            state_in = fsct_pkg::ST_RESP;
         end
         fsct_pkg::ST_RESP: begin
            state_in = fsct_pkg::ST_IDLE;
         end
         default: begin
            state_in = fsct_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------- handshake out
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         fsct_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         fsct_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign rsp_total_flow     = max_ff;
   assign rsp_job_completion = cout_ff;
   assign rsp_saturated      = sat_ff;

   // -------------------------------------------------------------- datapath
   always_comb begin
      job_in   = job_ff;
      cur_m_in = cur_m_ff;
      end_in   = end_ff;
      prev_in  = prev_ff;
      comp_in  = comp_ff;
      flow_in  = flow_ff;
      max_in   = max_ff;
      sat_in   = sat_ff;
      cout_in  = cout_ff;
      fv_in    = 1'b0;
      fm_in    = fm_ff;
      c_in     = c_ff;

      if (accept) begin
         job_in   = req_job_id;
         cur_m_in = MIDX_W'(req_first_machine);
         end_in   = end_clip;
         cout_in  = '0;
         if (op == fsct_pkg::OP_CLEAR) begin
            for (int i = 0; i < MACHINES; i++) begin
               comp_in[i] = '0;
               flow_in[i] = '0;
            end
            max_in = '0;
            sat_in = 1'b0;
         end
      end

      if (state_ff == fsct_pkg::ST_PREP) begin
         prev_in = prev_load;
      end

      if (state_ff == fsct_pkg::ST_WALK) begin
         comp_in[cur_m_ff] = c_new;
         prev_in           = c_new;
         c_in              = c_new;
         cout_in           = c_new;
         fm_in             = cur_m_ff;
         fv_in             = 1'b1;
         cur_m_in          = next_m;
         if (csum[COMP_W]) begin
            sat_in = 1'b1;
         end
      end

      if (fv_ff) begin
         flow_in[fm_ff] = f_new;
         if (f_new > max_ff) begin
            max_in = f_new;
         end
         if (fsum[FLOW_W]) begin
            sat_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsct_pkg::ST_IDLE;
         fv_ff    <= 1'b0;
         for (int i = 0; i < MACHINES; i++) begin
            comp_ff[i] <= '0;
            flow_ff[i] <= '0;
         end
         max_ff  <= '0;
         sat_ff  <= 1'b0;
         cout_ff <= '0;
      end else begin
         state_ff <= state_in;
         fv_ff    <= fv_in;
         comp_ff  <= comp_in;
         flow_ff  <= flow_in;
         max_ff   <= max_in;
         sat_ff   <= sat_in;
         cout_ff  <= cout_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      cur_m_ff <= cur_m_in;
      end_ff   <= end_in;
      prev_ff  <= prev_in;
      fm_ff    <= fm_in;
      c_ff     <= c_in;
   end

endmodule

// ----- rtl/fsct_checker.sv -----
// Port-level checker of the evaluator and its bind to the top level.
module fsct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [fsct_pkg::FLOW_W-1:0]   rsp_total_flow,
   input logic [fsct_pkg::COMP_W-1:0]   rsp_job_completion,
   input logic                          rsp_saturated
);

   // A result only ever appears while the item is still held as busy.
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid && !rsp_saturated && (rsp_total_flow == '0)))
      else $error("block not idle and cleared after reset");

   // A nonzero completion is also added to its machine's flow sum, so the largest flow
   // sum cannot still be zero when a nonzero completion is reported.
   a_zero_flow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_total_flow == '0)) |-> (rsp_job_completion == '0))
      else $error("nonzero completion with zero total flow");

endmodule

bind flow_shop_completion_time_eval fsct_checker u_fsct_checker (.*);
